// ----- sv/pidc_pkg.sv -----
// shared types and constants for the pid step block
// no dependencies
package pidc_pkg;

	localparam int DATA_W     = 16;             // measured, target, drive, gains
	localparam int ERR_W      = DATA_W + 1;     // target - measured
	localparam int DERR_W     = ERR_W + 1;      // error change
	localparam int INTEG_W    = 32;             // running integral
	localparam int LIMIT_W    = INTEG_W - 1;    // integral magnitude bound
	localparam int FRAC_W     = 8;              // q8.8 gains
	localparam int PROD_P_W   = DATA_W + ERR_W;
	localparam int PROD_I_W   = DATA_W + INTEG_W;
	localparam int PROD_D_W   = DATA_W + DERR_W;
	localparam int SUM_W      = PROD_I_W + 2;   // three products, headroom
	localparam int SHIFTED_W  = SUM_W - FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN      = 3'd0,
		CFG_INTEG_GAIN     = 3'd1,
		CFG_DERIV_GAIN     = 3'd2,
		CFG_INTEGRAL_LIMIT = 3'd3,
		CFG_CLAMP_ENABLE   = 3'd4,
		CFG_DRIVE_MAX      = 3'd5,
		CFG_DRIVE_MIN      = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain;
		logic signed [DATA_W-1:0] deriv_gain;
		logic [LIMIT_W-1:0]       integral_limit;
		logic                     clamp_enable;
		logic signed [DATA_W-1:0] drive_max;
		logic signed [DATA_W-1:0] drive_min;
	} cfg_t;

endpackage

// ----- sv/pid_step_with_clamps.sv -----
// pid step block: sample input register, loop state, gain products, output clamp
// depends on pidc_pkg, pidc_cfg, pidc_state, pidc_terms
//
// usage
//   sample channel: measured and target arrive with sample_valid; a word is taken
//   at a clock edge with sample_valid high and sample_stall low.
//   drive channel: one drive word per sample, shown with drive_valid; the
//   receiver takes it at an edge with drive_stall low, and may hold drive_stall
//   as long as it likes, the word stays put meanwhile.
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high, unknown indexes are dropped. write the
//   gains and limits only while no sample is in flight.
// timing
//   five register stages: sample register, error/integral stage, product stage,
//   sum stage, output register; a sample passes through them in this order to
//   drive_valid. one sample per cycle is sustained while drive_stall is low;
//   a stage refills as the next moves, so a stall backs up the stages behind.
// reset
//   arst_n clears the integral, the stored error, all stage valids and loads the
//   register defaults (gains 0, limit full scale, clamp off, bounds full range).
module pid_step_with_clamps (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [pidc_pkg::DATA_W-1:0]   measured,
	input  logic signed [pidc_pkg::DATA_W-1:0]   target,
	output logic                                 drive_valid,
	input  logic                                 drive_stall,
	output logic signed [pidc_pkg::DATA_W-1:0]   drive,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pidc_pkg::*;

	cfg_t                       cfg;

	// sample register
	logic                       valid_s1;
	logic                       en_s1;
	logic signed [DATA_W-1:0]   meas_s1;
	logic signed [DATA_W-1:0]   tgt_s1;

	// error / integral stage
	logic                       en_s2;
	logic                       valid_s2;
	logic signed [ERR_W-1:0]    err_s2;
	logic signed [INTEG_W-1:0]  integ_s2;
	logic signed [DERR_W-1:0]   derr_s2;

	// product and sum stages
	logic                       en_s3;
	logic                       valid_s4;
	logic signed [SHIFTED_W-1:0] shifted_s4;

	// output register
	logic                       en_out;
	logic signed [SHIFTED_W-1:0] upper_c;
	logic signed [SHIFTED_W-1:0] bounded_c;
	logic signed [DATA_W-1:0]   drive_q;
	logic                       drive_valid_q;

	pidc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// each stage moves when the one after it is empty or moving
	assign en_out       = !drive_valid_q || !drive_stall;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= sample_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			meas_s1 <= measured;
			tgt_s1  <= target;
		end
	end

	pidc_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (valid_s1),
		.up_en    (en_s2),
		.meas_s1  (meas_s1),
		.tgt_s1   (tgt_s1),
		.valid_s2 (valid_s2),
		.down_en  (en_s3),
		.err_s2   (err_s2),
		.integ_s2 (integ_s2),
		.derr_s2  (derr_s2)
	);

	pidc_terms u_terms (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.up_valid   (valid_s2),
		.up_en      (en_s3),
		.err_s2     (err_s2),
		.integ_s2   (integ_s2),
		.derr_s2    (derr_s2),
		.valid_s4   (valid_s4),
		.down_en    (en_out),
		.shifted_s4 (shifted_s4)
	);

	// upper bound first, then lower bound; with inverted bounds the lower wins
	always_comb begin
		upper_c = (shifted_s4 >= SHIFTED_W'(cfg.drive_max)) ? SHIFTED_W'(cfg.drive_max)
			: shifted_s4;
		bounded_c = (upper_c <= SHIFTED_W'(cfg.drive_min)) ? SHIFTED_W'(cfg.drive_min)
			: upper_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drive_valid_q <= 1'b0;
		else if (en_out)
			drive_valid_q <= valid_s4;
	end

	// bounded_c always lies within the 16-bit bounds, so the low bits are exact
	always_ff @(posedge clk) begin
		if (en_out && valid_s4)
			drive_q <= bounded_c[DATA_W-1:0];
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	a_empty_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!drive_valid |-> !sample_stall)
		else $error("sample stalled with empty output register");

endmodule

// ----- sv/pidc_cfg.sv -----
// configuration register file for the pid step block
// depends on pidc_pkg
module pidc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pidc_pkg::cfg_t                    cfg
);
	import pidc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.integral_limit <= '1;
			cfg_q.clamp_enable   <= 1'b0;
			cfg_q.drive_max      <= DATA_W'(16'sh7fff);
			cfg_q.drive_min      <= DATA_W'(16'sh8000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data[DATA_W-1:0];
				CFG_INTEG_GAIN:     cfg_q.integ_gain     <= cfg_data[DATA_W-1:0];
				CFG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data[DATA_W-1:0];
				CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[LIMIT_W-1:0];
				CFG_CLAMP_ENABLE:   cfg_q.clamp_enable   <= cfg_data[0];
				CFG_DRIVE_MAX:      cfg_q.drive_max      <= cfg_data[DATA_W-1:0];
				CFG_DRIVE_MIN:      cfg_q.drive_min      <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/pidc_state.sv -----
// error, saturating integral and error change stage; holds the loop state
// depends on pidc_pkg
module pidc_state (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pidc_pkg::cfg_t                     cfg,
	input  logic                               up_valid,
	output logic                               up_en,
	input  logic signed [pidc_pkg::DATA_W-1:0] meas_s1,
	input  logic signed [pidc_pkg::DATA_W-1:0] tgt_s1,
	output logic                               valid_s2,
	input  logic                               down_en,
	output logic signed [pidc_pkg::ERR_W-1:0]  err_s2,
	output logic signed [pidc_pkg::INTEG_W-1:0] integ_s2,
	output logic signed [pidc_pkg::DERR_W-1:0] derr_s2
);
	import pidc_pkg::*;

	logic signed [INTEG_W-1:0] integral_q;
	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [INTEG_W:0]   acc_c;
	logic signed [INTEG_W-1:0] sat_c;
	logic signed [INTEG_W-1:0] lim_c;
	logic signed [INTEG_W-1:0] next_integ_c;
	logic                      take;

	assign up_en = !valid_s2 || down_en;
	assign take  = up_valid && up_en;

	assign err_c = ERR_W'(tgt_s1) - ERR_W'(meas_s1);
	assign acc_c = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err_c);
	assign lim_c = $signed({1'b0, cfg.integral_limit});

	always_comb begin
		// saturate at the 32-bit bounds
		if (acc_c[INTEG_W] != acc_c[INTEG_W-1])
			sat_c = acc_c[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			sat_c = acc_c[INTEG_W-1:0];
		next_integ_c = sat_c;
		if (cfg.clamp_enable) begin
			if (next_integ_c > lim_c)
				next_integ_c = lim_c;
			if (next_integ_c < -lim_c)
				next_integ_c = -lim_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			integral_q   <= '0;
			prev_error_q <= '0;
		end else begin
			if (up_en)
				valid_s2 <= up_valid;
			if (take) begin
				integral_q   <= next_integ_c;
				prev_error_q <= err_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			derr_s2 <= DERR_W'(err_c) - DERR_W'(prev_error_q);
	end

	// the stored state is the stage payload
	assign err_s2   = prev_error_q;
	assign integ_s2 = integral_q;

	a_clamp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && cfg.clamp_enable |=>
		(integral_q <= $past(lim_c)) && (integral_q >= -$past(lim_c)))
		else $error("integral outside clamp limit");

	a_no_wrap_up: assert property (@(posedge clk) disable iff (!arst_n)
		take && !integral_q[INTEG_W-1] && !err_c[ERR_W-1] |=> !integral_q[INTEG_W-1])
		else $error("integral wrapped negative");

endmodule

// ----- sv/pidc_terms.sv -----
// gain products and q8.8 sum stages of the pid step block
// depends on pidc_pkg
module pidc_terms (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidc_pkg::cfg_t                        cfg,
	input  logic                                  up_valid,
	output logic                                  up_en,
	input  logic signed [pidc_pkg::ERR_W-1:0]     err_s2,
	input  logic signed [pidc_pkg::INTEG_W-1:0]   integ_s2,
	input  logic signed [pidc_pkg::DERR_W-1:0]    derr_s2,
	output logic                                  valid_s4,
	input  logic                                  down_en,
	output logic signed [pidc_pkg::SHIFTED_W-1:0] shifted_s4
);
	import pidc_pkg::*;

	logic                       valid_s3;
	logic                       en_s3;
	logic                       en_s4;
	logic signed [PROD_P_W-1:0] prod_p_s3;
	logic signed [PROD_I_W-1:0] prod_i_s3;
	logic signed [PROD_D_W-1:0] prod_d_s3;
	logic signed [SUM_W-1:0]    sum_c;

	assign en_s4 = !valid_s4 || down_en;
	assign en_s3 = !valid_s3 || en_s4;
	assign up_en = en_s3;

	assign sum_c = SUM_W'(prod_p_s3) + SUM_W'(prod_i_s3) + SUM_W'(prod_d_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3)
				valid_s3 <= up_valid;
			if (en_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			prod_p_s3 <= PROD_P_W'(cfg.prop_gain) * PROD_P_W'(err_s2);
			prod_i_s3 <= PROD_I_W'(cfg.integ_gain) * PROD_I_W'(integ_s2);
			prod_d_s3 <= PROD_D_W'(cfg.deriv_gain) * PROD_D_W'(derr_s2);
		end
		// arithmetic shift by the fraction width rounds toward minus infinity
		if (en_s4 && valid_s3)
			shifted_s4 <= sum_c[SUM_W-1:FRAC_W];
	end

endmodule
